[src/crgr_pkg.sv]
// Shared constants, types and codes of the rectangle and glyph raster engine.
package crgr_pkg;

  localparam int FRAME_WIDTH_DEF  = 128;
  localparam int FRAME_HEIGHT_DEF = 64;
  localparam int MAX_SCALE_DEF    = 8;

  // Working width of a signed pixel coordinate; it covers every edge plus extent.
  localparam int CW = 14;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  // A draw command as handed from the command front end to the rasterizer.
  typedef struct packed {
    logic               glyph;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic [10:0]        rect_width;
    logic [10:0]        rect_height;
    logic [31:0]        colour;
    logic [7:0]         glyph_bits;
    logic [3:0]         glyph_width;
    logic [2:0]         leftmost_bit;
    logic [3:0]         row_index;
    logic [3:0]         scale;
  } draw_cmd_t;

endpackage

[src/crgr_ifs.sv]
// Valid/ready channel interfaces for commands, read results and configuration.
interface crgr_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [11:0] x_pos;
  logic signed [11:0] y_pos;
  logic [10:0]        rect_width;
  logic [10:0]        rect_height;
  logic [31:0]        colour;
  logic [7:0]         glyph_bits;
  logic [3:0]         glyph_width;
  logic [2:0]         leftmost_bit;
  logic [3:0]         row_index;
  logic [3:0]         scale;

  modport source (
    output valid, kind, x_pos, y_pos, rect_width, rect_height, colour,
           glyph_bits, glyph_width, leftmost_bit, row_index, scale,
    input  ready
  );
  modport sink (
    input  valid, kind, x_pos, y_pos, rect_width, rect_height, colour,
           glyph_bits, glyph_width, leftmost_bit, row_index, scale,
    output ready
  );
endinterface

interface crgr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel;
  logic        in_range;

  modport source (output valid, pixel, in_range, input ready);
  modport sink (input valid, pixel, in_range, output ready);
endinterface

interface crgr_cfg_if;
  logic valid;
  logic ready;
  logic enabled;

  modport source (output valid, enabled, input ready);
  modport sink (input valid, enabled, output ready);
endinterface

[src/crgr_premul.sv]
// Registered premultiplication of a straight ARGB colour by its alpha.
module crgr_premul (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] colour,
  output logic [31:0] colour_pm
);

  // Exact truncating division by 255 for any product of two bytes.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    return t[15:8];
  endfunction

  logic [7:0]  alpha;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  assign alpha  = colour[31:24];
  assign prod_r = 16'(colour[23:16]) * 16'(alpha);
  assign prod_g = 16'(colour[15:8]) * 16'(alpha);
  assign prod_b = 16'(colour[7:0]) * 16'(alpha);

  always_ff @(posedge clk) begin
    if (load) begin
      colour_pm <= {alpha, div255(prod_r), div255(prod_g), div255(prod_b)};
    end
  end

endmodule

[src/crgr_fstore.sv]
// Frame store: one write port and one read port with registered read data.
module crgr_fstore #(
  parameter int DEPTH = crgr_pkg::FRAME_WIDTH_DEF * crgr_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [31:0]              wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [31:0]              rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[src/crgr_raster.sv]
// Rasterizer: clips a fill or glyph row and writes its pixels one per cycle.
module crgr_raster #(
  parameter int FRAME_WIDTH  = crgr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = crgr_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_SCALE    = crgr_pkg::MAX_SCALE_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  crgr_pkg::draw_cmd_t                          cmd,
  output logic                                         busy,
  output logic                                         wr_en,
  output logic [$clog2(FRAME_WIDTH*FRAME_HEIGHT)-1:0]  wr_addr,
  output logic [31:0]                                  wr_data
);
  import crgr_pkg::*;

  localparam int XW = $clog2(FRAME_WIDTH);
  localparam int YW = $clog2(FRAME_HEIGHT);
  localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
  localparam int SW = $clog2(MAX_SCALE + 1);
  localparam coord_t FW_C = coord_t'(FRAME_WIDTH);
  localparam coord_t FH_C = coord_t'(FRAME_HEIGHT);

  typedef enum logic [2:0] {
    R_IDLE  = 3'b001,
    R_SETUP = 3'b010,
    R_WALK  = 3'b100
  } rstate_t;

  rstate_t   state;
  draw_cmd_t cmd_q;
  logic [31:0] colour_pm;

  coord_t px;
  coord_t py;
  coord_t x_lo;
  coord_t x_hi;
  coord_t y_hi;
  logic [7:0]    mask;
  logic [SW-1:0] sx;
  logic [SW-1:0] s_q;

  // Setup values, computed from the held command.
  coord_t xs;
  coord_t ys;
  coord_t fx_end;
  coord_t fy_end;
  coord_t fx_lo;
  coord_t fy_lo;
  coord_t fx_hi;
  coord_t fy_hi;
  logic   fill_empty;
  logic [SW-1:0] s;
  logic [3:0]    ncols;
  logic [3:0]    top_cols;
  logic [8:0]    row_off;
  logic [8:0]    col_span;
  coord_t g_base_y;
  coord_t g_x_hi;
  coord_t g_y_hi;
  logic   glyph_empty;
  logic [7:0] mask_init;

  logic   in_frame;
  coord_t px_inc;
  coord_t py_inc;

  crgr_premul u_premul (
    .clk       (clk),
    .load      (start),
    .colour    (cmd.colour),
    .colour_pm (colour_pm)
  );

  always_comb begin
    xs     = coord_t'(cmd_q.x_pos);
    ys     = coord_t'(cmd_q.y_pos);
    fx_end = xs + coord_t'({3'b000, cmd_q.rect_width});
    fy_end = ys + coord_t'({3'b000, cmd_q.rect_height});
    fx_lo  = (xs < 0) ? '0 : xs;
    fy_lo  = (ys < 0) ? '0 : ys;
    fx_hi  = (fx_end > FW_C) ? FW_C : fx_end;
    fy_hi  = (fy_end > FH_C) ? FH_C : fy_end;
    fill_empty = (cmd_q.rect_width == '0) || (cmd_q.rect_height == '0) ||
                 (fx_lo >= fx_hi) || (fy_lo >= fy_hi);

    if (int'(cmd_q.scale) > MAX_SCALE) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = SW'(cmd_q.scale);
    end
    // Columns past bit zero have no mask bit and are never drawn.
    top_cols = {1'b0, cmd_q.leftmost_bit} + 4'd1;
    ncols    = (cmd_q.glyph_width < top_cols) ? cmd_q.glyph_width : top_cols;
    row_off  = 9'(cmd_q.row_index) * 9'(s);
    col_span = 9'(ncols) * 9'(s);
    g_base_y = ys + coord_t'({5'b00000, row_off});
    g_x_hi   = xs + coord_t'({5'b00000, col_span});
    g_y_hi   = g_base_y + coord_t'({{(CW-SW){1'b0}}, s});
    glyph_empty = (s == '0) || (ncols == '0);
    mask_init   = cmd_q.glyph_bits << (3'd7 - cmd_q.leftmost_bit);
  end

  assign px_inc   = px + coord_t'(1);
  assign py_inc   = py + coord_t'(1);
  assign in_frame = (px >= 0) && (px < FW_C) && (py >= 0) && (py < FH_C);

  assign busy    = (state != R_IDLE);
  assign wr_en   = (state == R_WALK) && in_frame && (!cmd_q.glyph || mask[7]);
  assign wr_addr = AW'(py[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(px[XW-1:0]);
  assign wr_data = colour_pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
    end else begin
      unique case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_SETUP;
          end
        end
        R_SETUP: begin
          if (cmd_q.glyph ? glyph_empty : fill_empty) begin
            state <= R_IDLE;
          end else begin
            state <= R_WALK;
          end
        end
        R_WALK: begin
          if ((px_inc == x_hi) && (py_inc == y_hi)) begin
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd;
    end
    if (state == R_SETUP) begin
      if (cmd_q.glyph) begin
        px   <= xs;
        x_lo <= xs;
        x_hi <= g_x_hi;
        py   <= g_base_y;
        y_hi <= g_y_hi;
      end else begin
        px   <= fx_lo;
        x_lo <= fx_lo;
        x_hi <= fx_hi;
        py   <= fy_lo;
        y_hi <= fy_hi;
      end
      mask <= mask_init;
      sx   <= '0;
      s_q  <= s;
    end else if (state == R_WALK) begin
      if (px_inc == x_hi) begin
        px   <= x_lo;
        py   <= py_inc;
        mask <= mask_init;
        sx   <= '0;
      end else begin
        px <= px_inc;
        if (sx == s_q - SW'(1)) begin
          sx   <= '0;
          mask <= mask << 1;
        end else begin
          sx <= sx + SW'(1);
        end
      end
    end
  end

endmodule

[src/clipped_rect_and_glyph_raster_top.sv]
// Top level of the clipped rectangle fill and glyph row raster engine.
//
// Usage. Commands arrive on the cmd channel, one beat per command: kind 0 fills
// a rectangle, kind 1 draws one glyph row, kind 2 reads one pixel, kind 3 is
// dropped. Only a read returns a beat on the rsp channel, carrying the stored
// premultiplied word and an in-range flag (out-of-frame reads give zero).
// The cfg channel writes the enable bit; it is always ready and should only
// be written while the engine is idle. With the enable bit clear, fill and
// glyph commands are accepted and discarded.
//
// Timing. A read is registered first as its address, then as the frame store
// read data, and last in the output register, which gives its result beat. A
// fill or glyph row goes through latching the command and colour, the clipping
// setup, the walk and the return of the sequencer to idle before the next
// command beat is taken. The walk covers N candidate pixels (clipped rectangle
// area, or glyph columns times scale squared); the single write port of the
// frame store limits it to one pixel per cycle. Commands are handled one at a
// time.
//
// Reset clears the enable bit, the sequencer and the output valid. The frame
// store is not cleared; the user fills it before reading. When the receiver
// stalls, the result waits in the output register and the next command is
// still taken; a second read then waits until the first result has left.
module clipped_rect_and_glyph_raster_top #(
  parameter int FRAME_WIDTH  = crgr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = crgr_pkg::FRAME_HEIGHT_DEF,
  parameter int MAX_SCALE    = crgr_pkg::MAX_SCALE_DEF
) (
  input logic        clk,
  input logic        rst,
  crgr_cmd_if.sink   cmd,
  crgr_rsp_if.source rsp,
  crgr_cfg_if.sink   cfg
);
  import crgr_pkg::*;

  localparam int XW    = $clog2(FRAME_WIDTH);
  localparam int YW    = $clog2(FRAME_HEIGHT);
  localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam coord_t FW_C = coord_t'(FRAME_WIDTH);
  localparam coord_t FH_C = coord_t'(FRAME_HEIGHT);

  // Command sequencer states.
  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_DRAW  = 4'b0010,
    T_READ  = 4'b0100,
    T_RDOUT = 4'b1000
  } tstate_t;

  tstate_t state;
  logic    enabled;

  logic    cmd_fire;
  logic    is_read;
  logic    is_draw;
  logic    start;
  draw_cmd_t draw_cmd;

  // Read address path.
  coord_t  rd_x;
  coord_t  rd_y;
  logic    rd_hit;
  logic [AW-1:0] rd_addr_next;
  logic [AW-1:0] rd_addr;
  logic          rd_in_range;
  logic [31:0]   rd_data;

  // Rasterizer write port.
  logic          draw_busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;

  // Output register.
  logic        out_valid;
  logic [31:0] out_pixel;
  logic        out_in_range;
  logic        out_free;

  assign cmd.ready = (state == T_IDLE);
  assign cfg.ready = 1'b1;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_read   = (kind_t'(cmd.kind) == KIND_READ);
  assign is_draw   = (kind_t'(cmd.kind) == KIND_FILL) || (kind_t'(cmd.kind) == KIND_GLYPH);
  assign start     = cmd_fire && is_draw && enabled;

  always_comb begin
    draw_cmd.glyph        = (kind_t'(cmd.kind) == KIND_GLYPH);
    draw_cmd.x_pos        = cmd.x_pos;
    draw_cmd.y_pos        = cmd.y_pos;
    draw_cmd.rect_width   = cmd.rect_width;
    draw_cmd.rect_height  = cmd.rect_height;
    draw_cmd.colour       = cmd.colour;
    draw_cmd.glyph_bits   = cmd.glyph_bits;
    draw_cmd.glyph_width  = cmd.glyph_width;
    draw_cmd.leftmost_bit = cmd.leftmost_bit;
    draw_cmd.row_index    = cmd.row_index;
    draw_cmd.scale        = cmd.scale;
  end

  // A read outside the frame points at entry zero and is masked at the output.
  assign rd_x   = coord_t'(cmd.x_pos);
  assign rd_y   = coord_t'(cmd.y_pos);
  assign rd_hit = (rd_x >= 0) && (rd_x < FW_C) && (rd_y >= 0) && (rd_y < FH_C);
  assign rd_addr_next = rd_hit ? AW'(rd_y[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(rd_x[XW-1:0])
                               : '0;

  assign out_free = !out_valid || rsp.ready;

  crgr_raster #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_SCALE    (MAX_SCALE)
  ) u_raster (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (draw_cmd),
    .busy    (draw_busy),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Writes and reads never overlap: a read is only issued once drawing is done.
  crgr_fstore #(
    .DEPTH (DEPTH)
  ) u_fstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == T_READ),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= T_IDLE;
      enabled <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        enabled <= cfg.enabled;
      end
      unique case (state)
        T_IDLE: begin
          if (cmd_fire && is_read) begin
            state <= T_READ;
          end else if (start) begin
            state <= T_DRAW;
          end
        end
        T_DRAW: begin
          if (!draw_busy) begin
            state <= T_IDLE;
          end
        end
        T_READ: begin
          state <= T_RDOUT;
        end
        T_RDOUT: begin
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire && is_read) begin
      rd_addr     <= rd_addr_next;
      rd_in_range <= rd_hit;
    end
  end

  // Output register: holds a result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if ((state == T_RDOUT) && out_free) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == T_RDOUT) && out_free) begin
      out_pixel    <= rd_in_range ? rd_data : '0;
      out_in_range <= rd_in_range;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.pixel    = out_pixel;
  assign rsp.in_range = out_in_range;

endmodule

[src/crgr_checker.sv]
// Port-level checks of the raster engine, bound to its top level.
module crgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic [1:0]  cmd_kind,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [31:0] rsp_pixel,
  input logic        rsp_in_range
);
  import crgr_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel) && $stable(rsp_in_range))
    else $error("result changed while stalled");

  a_out_of_frame_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_in_range |-> rsp_pixel == 32'd0)
    else $error("out-of-frame read returned a nonzero pixel");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_kind == KIND_READ) |=> !cmd_ready)
    else $error("command taken while a read is in flight");

  a_reset_no_result: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result shown right after reset");

endmodule

bind clipped_rect_and_glyph_raster_top crgr_checker u_crgr_checker (
  .clk          (clk),
  .rst          (rst),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_kind     (cmd.kind),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_pixel    (rsp.pixel),
  .rsp_in_range (rsp.in_range)
);

[tb/clipped_rect_and_glyph_raster_top_test.sv]
// Self-checking testbench of the clipped rectangle fill and glyph row raster engine.
module clipped_rect_and_glyph_raster_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crgr_pkg::*;

  localparam int FRAME_W   = FRAME_WIDTH_DEF;
  localparam int FRAME_H   = FRAME_HEIGHT_DEF;
  localparam int SCALE_CAP = MAX_SCALE_DEF;

  // The longest draw the engine can be busy with is a fill that covers the whole
  // frame, one pixel per cycle plus a little overhead. This is waited out before
  // any write of the enable bit and at the end of the run.
  localparam int DRAIN_CYCLES = FRAME_W * FRAME_H + 16;

  // The receiver holds off once for this many cycles so the engine backs up.
  localparam int HOLD_CYCLES = 400;

  // A correct run ends far below this limit.
  localparam int CYCLE_LIMIT = 4_000_000;

  // One command beat as the testbench sees it.
  typedef struct {
    kind_t              kind;
    logic signed [11:0] x_pos;
    logic signed [11:0] y_pos;
    logic [10:0]        rect_width;
    logic [10:0]        rect_height;
    logic [31:0]        colour;
    logic [7:0]         glyph_bits;
    logic [3:0]         glyph_width;
    logic [2:0]         leftmost_bit;
    logic [3:0]         row_index;
    logic [3:0]         scale;
  } raster_cmd_t;

  // One read result beat.
  typedef struct {
    logic [31:0] pixel;
    logic        in_range;
  } pixel_rsp_t;

  // The scoreboard keeps its own copy of the frame store and of the enable bit.
  // Every accepted command is applied to that copy in order; every read pushes
  // the word it should return onto a queue that the result beats are checked
  // against.
  class raster_scoreboard;
    logic [31:0] frame [FRAME_W * FRAME_H];
    bit          enabled;
    pixel_rsp_t  pending_reads [$];
    int          mismatches;
    int          results_seen;

    function void set_enabled(bit value);
      enabled = value;
    endfunction

    function int outstanding();
      return pending_reads.size();
    endfunction

    // Straight ARGB to premultiplied ARGB, each channel scaled by alpha / 255
    // with truncation, so an opaque colour passes through unchanged.
    function logic [31:0] premultiply(logic [31:0] argb);
      int unsigned a, r, g, b;
      a = argb[31:24];
      r = argb[23:16] * a / 255;
      g = argb[15:8] * a / 255;
      b = argb[7:0] * a / 255;
      return {a[7:0], r[7:0], g[7:0], b[7:0]};
    endfunction

    function void put_pixel(int px, int py, logic [31:0] word);
      if (px < 0 || px >= FRAME_W || py < 0 || py >= FRAME_H) return;
      frame[py * FRAME_W + px] = word;
    endfunction

    function void fill_rect(raster_cmd_t c, logic [31:0] word);
      int x0, y0, x1, y1;
      x0 = c.x_pos;
      y0 = c.y_pos;
      x1 = x0 + int'(c.rect_width);
      y1 = y0 + int'(c.rect_height);
      if (c.rect_width == 0 || c.rect_height == 0) return;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > FRAME_W) x1 = FRAME_W;
      if (y1 > FRAME_H) y1 = FRAME_H;
      for (int j = y0; j < y1; j++)
        for (int i = x0; i < x1; i++)
          frame[j * FRAME_W + i] = word;
    endfunction

    // Column k of the row takes bit leftmost_bit - k; columns past bit zero
    // have no bit at all. Each set bit grows into a square of side scale.
    function void glyph_row(raster_cmd_t c, logic [31:0] word);
      int s, base_y, top, bit_pos;
      s = c.scale;
      if (s > SCALE_CAP) s = SCALE_CAP;
      if (s == 0) return;
      top = c.leftmost_bit;
      base_y = int'(c.y_pos) + int'(c.row_index) * s;
      for (int k = 0; k < int'(c.glyph_width) && k <= top; k++) begin
        bit_pos = top - k;
        if (c.glyph_bits[bit_pos]) begin
          for (int sy = 0; sy < s; sy++)
            for (int sx = 0; sx < s; sx++)
              put_pixel(int'(c.x_pos) + k * s + sx, base_y + sy, word);
        end
      end
    endfunction

    function void note_command(raster_cmd_t c);
      pixel_rsp_t r;
      int px, py;
      px = c.x_pos;
      py = c.y_pos;
      case (c.kind)
        KIND_READ: begin
          if (px >= 0 && px < FRAME_W && py >= 0 && py < FRAME_H) begin
            r.pixel    = frame[py * FRAME_W + px];
            r.in_range = 1'b1;
          end else begin
            r.pixel    = '0;
            r.in_range = 1'b0;
          end
          pending_reads.push_back(r);
        end
        KIND_FILL: if (enabled) fill_rect(c, premultiply(c.colour));
        KIND_GLYPH: if (enabled) glyph_row(c, premultiply(c.colour));
        default: ;
      endcase
    endfunction

    function void report(string what, pixel_rsp_t want, logic [31:0] pixel, logic in_range);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected pixel %h in_range %b, got pixel %h in_range %b",
                 $realtime, what, want.pixel, want.in_range, pixel, in_range);
    endfunction

    function void check_result(logic [31:0] pixel, logic in_range);
      pixel_rsp_t want;
      results_seen++;
      if (pending_reads.size() == 0) begin
        want.pixel    = 'x;
        want.in_range = 1'bx;
        report("result with no read waiting", want, pixel, in_range);
        return;
      end
      want = pending_reads.pop_front();
      if (pixel !== want.pixel || in_range !== want.in_range)
        report("read result mismatch", want, pixel, in_range);
    endfunction

    // Reads that never got their result count as failures too.
    function int failures();
      return mismatches + pending_reads.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  crgr_cmd_if cmd_ch ();
  crgr_rsp_if rsp_ch ();
  crgr_cfg_if cfg_ch ();

  raster_scoreboard board = new();

  // Set by the stimulus during one long stretch of the run; neither side idles
  // while it is high.
  bit steady = 1'b0;
  int cycle_count = 0;

  clipped_rect_and_glyph_raster_top #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H),
    .MAX_SCALE   (SCALE_CAP)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  always #1 clk = ~clk;

  // Watchdog. A hang anywhere in the run ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result beats are taken at the rising edge, where both valid and ready still
  // hold the values set up during the previous cycle.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.pixel, rsp_ch.in_range);
  end

  // Receiver side. Ready changes only at the falling edge. It drops at random
  // about 18 times in a hundred, except in the steady stretch, and once early in
  // the run it stays low for a long hold so that a read result sits in the
  // output register, the next read backs up behind it and the command channel
  // stalls while the sender keeps offering beats.
  initial begin : result_sink
    bit hold_done;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && board.results_seen >= 50) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        rsp_ch.ready <= steady || ($urandom_range(99) >= 18);
      end
    end
  end

  // Every task below starts and ends at a falling edge. Valid is never lowered
  // at the end of a beat; the next call decides whether it goes low to idle the
  // channel or stays high for the next beat, so no signal gets two assignments
  // in one time step.
  task automatic send_command(raster_cmd_t c);
    if (!steady) begin
      while ($urandom_range(99) < 18) begin
        cmd_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.kind         <= c.kind;
    cmd_ch.x_pos        <= c.x_pos;
    cmd_ch.y_pos        <= c.y_pos;
    cmd_ch.rect_width   <= c.rect_width;
    cmd_ch.rect_height  <= c.rect_height;
    cmd_ch.colour       <= c.colour;
    cmd_ch.glyph_bits   <= c.glyph_bits;
    cmd_ch.glyph_width  <= c.glyph_width;
    cmd_ch.leftmost_bit <= c.leftmost_bit;
    cmd_ch.row_index    <= c.row_index;
    cmd_ch.scale        <= c.scale;
    do @(posedge clk); while (!cmd_ch.ready);
    board.note_command(c);
    @(negedge clk);
  endtask

  // The enable bit is only written while the engine is idle.
  task automatic write_enable(bit value);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.enabled <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    board.set_enabled(value);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every read has answered, then lets the longest possible draw
  // finish, since a draw gives no beat to tell when it is done.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Every field random over its full width; command builders then overwrite the
  // fields that matter, so the ignored fields still see every bit toggle.
  function automatic raster_cmd_t noise_command();
    raster_cmd_t c;
    c.kind         = kind_t'($urandom_range(3));
    c.x_pos        = 12'($urandom);
    c.y_pos        = 12'($urandom);
    c.rect_width   = 11'($urandom);
    c.rect_height  = 11'($urandom);
    c.colour       = $urandom;
    c.glyph_bits   = 8'($urandom);
    c.glyph_width  = 4'($urandom);
    c.leftmost_bit = 3'($urandom);
    c.row_index    = 4'($urandom);
    c.scale        = 4'($urandom);
    return c;
  endfunction

  function automatic raster_cmd_t read_at(int x, int y);
    raster_cmd_t c;
    c       = noise_command();
    c.kind  = KIND_READ;
    c.x_pos = 12'(x);
    c.y_pos = 12'(y);
    return c;
  endfunction

  function automatic raster_cmd_t fill_at(int x, int y, int w, int h, logic [31:0] argb);
    raster_cmd_t c;
    c             = noise_command();
    c.kind        = KIND_FILL;
    c.x_pos       = 12'(x);
    c.y_pos       = 12'(y);
    c.rect_width  = 11'(w);
    c.rect_height = 11'(h);
    c.colour      = argb;
    return c;
  endfunction

  function automatic raster_cmd_t glyph_at(int x, int y, int bits, int width, int top,
                                           int row, int scale, logic [31:0] argb);
    raster_cmd_t c;
    c              = noise_command();
    c.kind         = KIND_GLYPH;
    c.x_pos        = 12'(x);
    c.y_pos        = 12'(y);
    c.glyph_bits   = 8'(bits);
    c.glyph_width  = 4'(width);
    c.leftmost_bit = 3'(top);
    c.row_index    = 4'(row);
    c.scale        = 4'(scale);
    c.colour       = argb;
    return c;
  endfunction

  // Random colour with opaque and fully transparent alpha made common, since
  // those are the two ends of the premultiply.
  function automatic logic [31:0] random_colour();
    logic [31:0] argb;
    int roll;
    argb = $urandom;
    roll = $urandom_range(9);
    if (roll < 2) argb[31:24] = 8'hff;
    else if (roll == 2) argb[31:24] = 8'h00;
    return argb;
  endfunction

  // One random command. Reads land mostly inside the frame, fills and glyph
  // rows mostly near it so clipping on every edge is common; a small share of
  // reads and fills use coordinates over the full signed range. Draw sizes stay
  // small to keep the run short; big fills are issued separately.
  function automatic raster_cmd_t random_command();
    raster_cmd_t c;
    int roll;
    c    = noise_command();
    roll = $urandom_range(99);
    if (roll < 40) begin
      c.kind = KIND_READ;
      if ($urandom_range(9) < 8) begin
        c.x_pos = 12'($urandom_range(FRAME_W - 1));
        c.y_pos = 12'($urandom_range(FRAME_H - 1));
      end
    end else if (roll < 70) begin
      c.kind = KIND_FILL;
      if ($urandom_range(9) < 8) begin
        c.x_pos = 12'(int'($urandom_range(FRAME_W + 32)) - 20);
        c.y_pos = 12'(int'($urandom_range(FRAME_H + 32)) - 20);
      end
      c.rect_width  = 11'($urandom_range(16));
      c.rect_height = 11'($urandom_range(16));
      c.colour      = random_colour();
    end else if (roll < 95) begin
      c.kind  = KIND_GLYPH;
      c.x_pos = 12'(int'($urandom_range(FRAME_W + 40)) - 30);
      c.y_pos = 12'(int'($urandom_range(FRAME_H + 136)) - 130);
      if ($urandom_range(9) < 8) c.scale = 4'($urandom_range(3, 1));
      c.colour = random_colour();
    end else begin
      c.kind = KIND_NONE;
    end
    return c;
  endfunction

  // A fill that covers all of the frame with its extents near the top
  // of their range.
  function automatic raster_cmd_t big_fill();
    return fill_at(int'($urandom_range(40)) - 40, int'($urandom_range(40)) - 40,
                   $urandom_range(2047, 1024), $urandom_range(2047, 1024), random_colour());
  endfunction

  task automatic random_phase(int count, bit with_steady_stretch);
    for (int n = 0; n < count; n++) begin
      if (with_steady_stretch) steady = (n >= 400 && n < 700);
      if (n % 250 == 125) send_command(big_fill());
      else send_command(random_command());
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.kind         = KIND_NONE;
    cmd_ch.x_pos        = '0;
    cmd_ch.y_pos        = '0;
    cmd_ch.rect_width   = '0;
    cmd_ch.rect_height  = '0;
    cmd_ch.colour       = '0;
    cmd_ch.glyph_bits   = '0;
    cmd_ch.glyph_width  = '0;
    cmd_ch.leftmost_bit = '0;
    cmd_ch.row_index    = '0;
    cmd_ch.scale        = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.enabled      = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_enable(1'b1);

    // The frame store holds garbage after reset, so the first draw clears it
    // entirely; every later read then hits a written word. The extents are the
    // largest the fields allow and the corner sits off the frame.
    send_command(fill_at(-5, -3, 2047, 2047, 32'hffff_ffff));
    // Frame corners, then coordinates just past the right, left and bottom edges
    // and at the extremes of the signed range.
    send_command(read_at(0, 0));
    send_command(read_at(FRAME_W - 1, FRAME_H - 1));
    send_command(read_at(FRAME_W, 0));
    send_command(read_at(-1, FRAME_H - 1));
    send_command(read_at(0, FRAME_H));
    send_command(read_at(2047, -2048));
    // Empty rectangles: zero width, zero height, wholly outside on either side.
    send_command(fill_at(0, 0, 0, 10, 32'hff00_00ff));
    send_command(fill_at(0, 0, 10, 0, 32'hff00_00ff));
    send_command(fill_at(2047, 2047, 2047, 2047, 32'hff00_00ff));
    send_command(fill_at(-2048, -2048, 2047, 2047, 32'hff00_00ff));
    // A half-transparent fill clipped at the bottom right, and a fully
    // transparent one that must store zero.
    send_command(fill_at(FRAME_W - 8, FRAME_H - 4, 20, 20, 32'h80ff_4020));
    send_command(fill_at(10, 10, 3, 2, 32'h00ab_cdef));
    send_command(read_at(FRAME_W - 1, FRAME_H - 1));
    send_command(read_at(10, 10));
    // Glyph rows: a plain row at scale one; a width past the available bits
    // with a scale above the cap; a scale of zero; the last row index drawn
    // across the left edge; a single column taken from bit zero.
    send_command(glyph_at(0, 0, 8'ha5, 8, 7, 0, 1, 32'hff00_ff00));
    send_command(glyph_at(20, 0, 8'hff, 15, 3, 1, 15, 32'hc0c0_8040));
    send_command(glyph_at(30, 0, 8'hff, 8, 7, 0, 0, 32'hff12_3456));
    send_command(glyph_at(-6, -60, 8'h81, 8, 7, 15, 4, 32'hff65_4321));
    send_command(glyph_at(100, 40, 8'h01, 1, 0, 2, 2, 32'h7fff_ffff));
    // The unused kind is dropped without a result.
    begin
      raster_cmd_t junk;
      junk      = noise_command();
      junk.kind = KIND_NONE;
      send_command(junk);
    end
    send_command(read_at(0, 0));
    send_command(read_at(26, 9));
    send_command(read_at(0, 0));
    send_command(read_at(101, 44));

    // With drawing disabled the store must not change, yet reads still answer.
    drain();
    write_enable(1'b0);
    random_phase(150, 1'b0);

    drain();
    write_enable(1'b1);
    random_phase(1200, 1'b1);

    drain();
    write_enable(1'b0);
    random_phase(100, 1'b0);

    drain();
    if (board.failures() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
